// File: sv/priority_round_robin_scheduler_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority round-robin scheduler
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PRR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prr checker: property failed");

// Check cons in the cycle after ante.
`define PRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prr checker: property failed");

`endif

// File: sv/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg
// Types and constants shared by the priority round-robin scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

    localparam int SLOT_DEPTH = 16;
    localparam int PRIO_BITS  = 8;
    localparam int IDX_W      = $clog2(SLOT_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int IN_PRIO_W  = 8;
    localparam int LIMIT_W    = 5;

    typedef enum logic [1:0] {
        ST_UNUSED     = 2'd0,
        ST_RUNNABLE   = 2'd1,
        ST_RUNNING    = 2'd2,
        ST_TERMINATED = 2'd3
    } t_slot_st;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_ADD      = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_SETPRIO  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADIDX = 2'd2,
        STAT_IDLE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_MOD,
        S_SCAN1,
        S_SCAN2,
        S_WR_OLD,
        S_WR_NEW,
        S_DONE
    } t_fsm;

    typedef struct packed {
        logic [IDX_W-1:0] chosen;
        logic             switched;
        t_status          status;
    } t_res;

    typedef struct packed {
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_addr;
        logic                 st_we;
        logic [IDX_W-1:0]     st_waddr;
        t_slot_st             st_wdata;
        logic                 pr_we;
        logic [IDX_W-1:0]     pr_waddr;
        logic [PRIO_BITS-1:0] pr_wdata;
    } t_mem_req;

    typedef struct packed {
        t_slot_st             st;
        logic [PRIO_BITS-1:0] prio;
    } t_mem_rsp;

endpackage

`default_nettype wire

// File: sv/prr_if.sv
// ----------------------------------------------------------------------------
// prr_if
// Valid/ready channels of the scheduler: configuration, request, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prr_cfg_if;
    import prr_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prr_req_if;
    import prr_pkg::*;
    logic                 valid;
    logic                 ready;
    t_op                  opcode;
    logic [IDX_W-1:0]     task_index;
    logic [IN_PRIO_W-1:0] new_priority;
    modport source (output valid, output opcode, output task_index,
                    output new_priority, input ready);
    modport sink   (input valid, input opcode, input task_index,
                    input new_priority, output ready);
endinterface

interface prr_res_if;
    import prr_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] chosen_task;
    logic             switched;
    t_status          status;
    modport source (output valid, output chosen_task, output switched,
                    output status, input ready);
    modport sink   (input valid, input chosen_task, input switched,
                    input status, output ready);
endinterface

`default_nettype wire

// File: sv/prr_slot_mem.sv
// ----------------------------------------------------------------------------
// prr_slot_mem
// Slot state and priority tables with a registered synchronous read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prr_slot_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prr_pkg::t_mem_req  i_mreq,
    output prr_pkg::t_mem_rsp  o_mrsp
);
    import prr_pkg::*;

    logic [1:0]           r_mem_st [SLOT_DEPTH];
    logic [PRIO_BITS-1:0] r_mem_pr [SLOT_DEPTH];
    logic [1:0]           r_rd_st;
    logic [PRIO_BITS-1:0] r_rd_pr;
    logic                 r_st0_wr;
    logic                 r_pr0_wr;
    logic                 r_st_dflt;
    logic                 r_pr_dflt;

    always_ff @(posedge i_clk) begin
        if (i_mreq.st_we) begin
            r_mem_st[i_mreq.st_waddr] <= i_mreq.st_wdata;
        end
        if (i_mreq.pr_we) begin
            r_mem_pr[i_mreq.pr_waddr] <= i_mreq.pr_wdata;
        end
        if (i_mreq.rd_en) begin
            r_rd_st <= r_mem_st[i_mreq.rd_addr];
            r_rd_pr <= r_mem_pr[i_mreq.rd_addr];
        end
    end

    // Slot 0 holds the running boot task until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st0_wr  <= 1'b0;
            r_pr0_wr  <= 1'b0;
            r_st_dflt <= 1'b0;
            r_pr_dflt <= 1'b0;
        end else begin
            if (i_mreq.st_we && i_mreq.st_waddr == '0) begin
                r_st0_wr <= 1'b1;
            end
            if (i_mreq.pr_we && i_mreq.pr_waddr == '0) begin
                r_pr0_wr <= 1'b1;
            end
            if (i_mreq.rd_en) begin
                r_st_dflt <= (i_mreq.rd_addr == '0) && !r_st0_wr;
                r_pr_dflt <= (i_mreq.rd_addr == '0) && !r_pr0_wr;
            end
        end
    end

    assign o_mrsp.st   = r_st_dflt ? ST_RUNNING : t_slot_st'(r_rd_st);
    assign o_mrsp.prio = r_pr_dflt ? '0 : r_rd_pr;

endmodule

`default_nettype wire

// File: sv/prr_seq.sv
// ----------------------------------------------------------------------------
// prr_seq
// Request sequencer: table updates and the two-pass schedule scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prr_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    prr_req_if.sink                     i_req,
    input  logic [prr_pkg::CNT_W-1:0]   i_limit,
    output logic                        o_res_valid,
    output prr_pkg::t_res               o_res,
    input  logic                        i_res_ready,
    output prr_pkg::t_mem_req           o_mreq,
    input  prr_pkg::t_mem_rsp           i_mrsp
);
    import prr_pkg::*;

    t_fsm                 r_state,    n_state;
    t_op                  r_op,       n_op;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic [PRIO_BITS-1:0] r_prio,     n_prio;
    logic [CNT_W-1:0]     r_total,    n_total;
    logic [IDX_W-1:0]     r_cur,      n_cur;
    logic [CNT_W-1:0]     r_issue,    n_issue;
    logic [IDX_W-1:0]     r_scan,     n_scan;
    logic                 r_pend,     n_pend;
    logic [IDX_W-1:0]     r_pend_slot, n_pend_slot;
    logic                 r_found,    n_found;
    logic [PRIO_BITS-1:0] r_top,      n_top;
    t_slot_st             r_cur_st,   n_cur_st;
    logic                 r_hit,      n_hit;
    logic [IDX_W-1:0]     r_pick,     n_pick;
    t_res                 r_res,      n_res;

    logic             issue;
    logic             elig;
    logic [IDX_W-1:0] cur_next;
    logic [IDX_W-1:0] scan_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= CNT_W'(1);
            r_cur   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_prio      <= n_prio;
        r_issue     <= n_issue;
        r_scan      <= n_scan;
        r_pend_slot <= n_pend_slot;
        r_top       <= n_top;
        r_cur_st    <= n_cur_st;
        r_pick      <= n_pick;
        r_res       <= n_res;
    end

    assign elig = (i_mrsp.st == ST_RUNNABLE) || (i_mrsp.st == ST_RUNNING);
    // Round-robin successors, wrapping at the table fill.
    assign cur_next  = ({1'b0, r_cur} + CNT_W'(1) == r_total) ? '0 : r_cur + IDX_W'(1);
    assign scan_next = ({1'b0, r_scan} + CNT_W'(1) == r_total) ? '0 : r_scan + IDX_W'(1);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_prio      = r_prio;
        n_total     = r_total;
        n_cur       = r_cur;
        n_issue     = r_issue;
        n_scan      = r_scan;
        n_pend      = 1'b0;
        n_pend_slot = r_pend_slot;
        n_found     = r_found;
        n_top       = r_top;
        n_cur_st    = r_cur_st;
        n_hit       = r_hit;
        n_pick      = r_pick;
        n_res       = r_res;
        issue       = 1'b0;
        o_mreq      = '0;
        i_req.ready = (r_state == S_IDLE);
        o_res_valid = 1'b0;
        o_res       = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.opcode;
                    n_idx   = i_req.task_index;
                    n_prio  = i_req.new_priority[PRIO_BITS-1:0];
                    n_issue = '0;
                    n_found = 1'b0;
                    n_hit   = 1'b0;
                    unique case (i_req.opcode) inside
                        OP_SCHEDULE:           n_state = S_SCAN1;
                        OP_ADD:                n_state = S_ADD;
                        OP_REMOVE, OP_SETPRIO: n_state = S_MOD;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (r_total >= i_limit) begin
                    n_res = '{chosen: '0, switched: 1'b0, status: STAT_FULL};
                end else begin
                    o_mreq.st_we    = 1'b1;
                    o_mreq.st_waddr = r_total[IDX_W-1:0];
                    o_mreq.st_wdata = ST_RUNNABLE;
                    o_mreq.pr_we    = 1'b1;
                    o_mreq.pr_waddr = r_total[IDX_W-1:0];
                    o_mreq.pr_wdata = PRIO_BITS'(1);
                    n_total = r_total + CNT_W'(1);
                    n_res = '{chosen: r_total[IDX_W-1:0], switched: 1'b0, status: STAT_OK};
                end
                n_state = S_DONE;
            end
            S_MOD: begin
                if ({1'b0, r_idx} >= r_total) begin
                    n_res = '{chosen: '0, switched: 1'b0, status: STAT_BADIDX};
                end else begin
                    if (r_op == OP_REMOVE) begin
                        o_mreq.st_we    = 1'b1;
                        o_mreq.st_waddr = r_idx;
                        o_mreq.st_wdata = ST_TERMINATED;
                    end else begin
                        o_mreq.pr_we    = 1'b1;
                        o_mreq.pr_waddr = r_idx;
                        o_mreq.pr_wdata = r_prio;
                    end
                    n_res = '{chosen: '0, switched: 1'b0, status: STAT_OK};
                end
                n_state = S_DONE;
            end
            S_SCAN1: begin
                // Pass one: find the top priority among eligible slots.
                issue          = (r_issue < r_total);
                o_mreq.rd_en   = issue;
                o_mreq.rd_addr = r_issue[IDX_W-1:0];
                n_pend         = issue;
                n_pend_slot    = r_issue[IDX_W-1:0];
                if (issue) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                if (r_pend) begin
                    if (elig && (!r_found || i_mrsp.prio > r_top)) begin
                        n_top   = i_mrsp.prio;
                        n_found = 1'b1;
                    end
                    if (r_pend_slot == r_cur) begin
                        n_cur_st = i_mrsp.st;
                    end
                end
                if (!issue && !r_pend) begin
                    if (!r_found) begin
                        n_res   = '{chosen: r_cur, switched: 1'b0, status: STAT_IDLE};
                        n_state = S_DONE;
                    end else begin
                        n_issue = '0;
                        n_scan  = cur_next;
                        n_state = S_SCAN2;
                    end
                end
            end
            S_SCAN2: begin
                // Pass two: first slot at top priority after the current one.
                issue          = (r_issue < r_total) && !r_hit;
                o_mreq.rd_en   = issue;
                o_mreq.rd_addr = r_scan;
                n_pend         = issue;
                n_pend_slot    = r_scan;
                if (issue) begin
                    n_issue = r_issue + CNT_W'(1);
                    n_scan  = scan_next;
                end
                if (r_pend && !r_hit && elig && i_mrsp.prio == r_top) begin
                    n_hit  = 1'b1;
                    n_pick = r_pend_slot;
                end
                if (r_hit) begin
                    n_state = S_WR_OLD;
                end else if (!issue && !r_pend) begin
                    n_pick  = r_cur;
                    n_state = S_WR_OLD;
                end
            end
            S_WR_OLD: begin
                if (r_pick != r_cur) begin
                    if (r_cur_st == ST_RUNNING) begin
                        o_mreq.st_we    = 1'b1;
                        o_mreq.st_waddr = r_cur;
                        o_mreq.st_wdata = ST_RUNNABLE;
                    end
                    n_state = S_WR_NEW;
                end else begin
                    n_res   = '{chosen: r_cur, switched: 1'b0, status: STAT_OK};
                    n_state = S_DONE;
                end
            end
            S_WR_NEW: begin
                o_mreq.st_we    = 1'b1;
                o_mreq.st_waddr = r_pick;
                o_mreq.st_wdata = ST_RUNNING;
                n_cur   = r_pick;
                n_res   = '{chosen: r_pick, switched: 1'b1, status: STAT_OK};
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/priority_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_core
// Strict-priority task scheduler with round-robin tie-break over a slot table.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: opcode (schedule, add, remove, set priority),
//   task_index and new_priority. It is taken when valid and ready are high.
//   o_res returns exactly one result per request: chosen_task, switched and
//   status, under valid/ready.
//   i_cfg writes task_limit (most slots that add may fill); write it only
//   while no request is in flight. It is always ready.
// Sequencing:
//   One request at a time. Schedule reads the slot tables in up to two passes
//   through the one synchronous read port, one slot per cycle.
// Reset:
//   Slot 0 runs at priority 0, one slot in use, task_limit is 16.
//   The tables need no clearing pass; slot 0 reads as its boot value until
//   first written, and other slots are written by add before any read.
// Stall:
//   A finished result sits in the output register while the receiver holds
//   ready low; the sequencer finishes the next request and then holds it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_scheduler_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prr_cfg_if.sink   i_cfg,
    prr_req_if.sink   i_req,
    prr_res_if.source o_res
);
    import prr_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid, n_out_valid;
    t_res               r_out,       n_out;

    logic [CNT_W-1:0] limit_cap;
    logic             seq_valid;
    t_res             seq_res;
    logic             seq_ready;
    t_mem_req         mreq;
    t_mem_rsp         mrsp;

    // Configuration: one register, always ready.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(SLOT_DEPTH);
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    // Cap the limit at the table depth.
    assign limit_cap = (r_limit > LIMIT_W'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH)
                                                        : CNT_W'(r_limit);

    prr_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mreq  (mreq),
        .o_mrsp  (mrsp)
    );

    prr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_limit     (limit_cap),
        .o_res_valid (seq_valid),
        .o_res       (seq_res),
        .i_res_ready (seq_ready),
        .o_mreq      (mreq),
        .i_mrsp      (mrsp)
    );

    // Output register: load when empty or being drained.
    assign seq_ready = !r_out_valid || o_res.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (seq_valid && seq_ready) begin
            n_out_valid = 1'b1;
            n_out       = seq_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.chosen_task = r_out.chosen;
    assign o_res.switched    = r_out.switched;
    assign o_res.status      = r_out.status;

endmodule

`default_nettype wire

// File: sv/prr_checker.sv
// ----------------------------------------------------------------------------
// prr_checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "priority_round_robin_scheduler_core_defines.svh"

module prr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic [prr_pkg::IDX_W-1:0] i_chosen,
    input logic                      i_switched,
    input logic [1:0]                i_status
);
    import prr_pkg::*;

    `PRR_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)
    `PRR_ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable({i_chosen, i_switched, i_status}))
    // One request in flight: ready drops right after an accept.
    `PRR_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
    `PRR_ASSERT_NOW(a_switch_ok, i_clk, i_rst_n, i_res_valid && i_switched, i_status == STAT_OK)
    `PRR_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_res_valid && (i_status == STAT_FULL || i_status == STAT_BADIDX), i_chosen == '0 && !i_switched)

endmodule

bind priority_round_robin_scheduler_core prr_checker u_prr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_chosen    (o_res.chosen_task),
    .i_switched  (o_res.switched),
    .i_status    (o_res.status)
);

`default_nettype wire

// File: bench/tb_priority_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_priority_round_robin_scheduler_core
// Self-checking bench for the priority round-robin scheduler. A shadow task
// table tracks every accepted request and predicts its result. Directed
// requests cover the corner cases. Random phases under several task limits
// follow; all but one idle the request and result channels at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_priority_round_robin_scheduler_core;
    import prr_pkg::*;

    typedef struct {
        t_op                  op;
        logic [IDX_W-1:0]     idx;
        logic [IN_PRIO_W-1:0] prio;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    prr_cfg_if cfg_ch();
    prr_req_if req_ch();
    prr_res_if res_ch();

    priority_round_robin_scheduler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the task table and the limit register
    t_slot_st             shadow_st[SLOT_DEPTH];
    logic [PRIO_BITS-1:0] shadow_prio[SLOT_DEPTH];
    int                   shadow_total;
    int                   shadow_running;
    logic [LIMIT_W-1:0]   shadow_limit;

    t_request request_q[$];   // requests waiting for the driver
    t_res     outcome_q[$];   // predicted results, oldest first
    int       mismatch_cnt = 0;
    bit       no_idle = 1'b0; // set to run a phase without any idling

    int send_wait = 0;
    int recv_wait = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Work out the result of one request and advance the shadow table.
    function automatic t_res apply_request(t_request r);
        int                   i;
        int                   s;
        int                   start;
        int                   pick;
        int                   lim;
        logic                 found;
        logic                 hit;
        logic [PRIO_BITS-1:0] top;
        t_res                 res;
        res.chosen   = '0;
        res.switched = 1'b0;
        res.status   = STAT_OK;
        lim = (shadow_limit < SLOT_DEPTH) ? int'(shadow_limit) : SLOT_DEPTH;
        case (r.op)
            OP_SCHEDULE: begin
                // First pass: highest priority among runnable or running slots
                found = 1'b0;
                top   = '0;
                for (i = 0; i < shadow_total; i++) begin
                    if ((shadow_st[i] == ST_RUNNABLE || shadow_st[i] == ST_RUNNING) &&
                        (!found || shadow_prio[i] > top)) begin
                        top   = shadow_prio[i];
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    // Nothing runnable: report the current slot, change nothing
                    res.chosen = shadow_running[IDX_W-1:0];
                    res.status = STAT_IDLE;
                end else begin
                    // Second pass: round-robin from the slot after the running one
                    start = (shadow_running + 1) % shadow_total;
                    pick  = shadow_running;
                    hit   = 1'b0;
                    for (i = 0; i < shadow_total; i++) begin
                        s = (start + i) % shadow_total;
                        if (!hit && (shadow_st[s] == ST_RUNNABLE ||
                                     shadow_st[s] == ST_RUNNING) &&
                            shadow_prio[s] == top) begin
                            pick = s;
                            hit  = 1'b1;
                        end
                    end
                    if (pick != shadow_running) begin
                        // A terminated running task stays terminated
                        if (shadow_st[shadow_running] == ST_RUNNING)
                            shadow_st[shadow_running] = ST_RUNNABLE;
                        shadow_st[pick] = ST_RUNNING;
                        shadow_running  = pick;
                        res.switched    = 1'b1;
                    end
                    res.chosen = pick[IDX_W-1:0];
                end
            end
            OP_ADD: begin
                if (shadow_total >= lim) begin
                    res.status = STAT_FULL;
                end else begin
                    shadow_st[shadow_total]   = ST_RUNNABLE;
                    shadow_prio[shadow_total] = PRIO_BITS'(1);
                    res.chosen   = shadow_total[IDX_W-1:0];
                    shadow_total = shadow_total + 1;
                end
            end
            default: begin
                if (int'(r.idx) >= shadow_total) begin
                    res.status = STAT_BADIDX;
                end else if (r.op == OP_REMOVE) begin
                    shadow_st[r.idx] = ST_TERMINATED;
                end else begin
                    shadow_prio[r.idx] = r.prio[PRIO_BITS-1:0];
                end
            end
        endcase
        return res;
    endfunction

    // Idle length: mostly none, sometimes short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic push_request(t_op op, int idx, int prio);
        t_request r;
        r.op   = op;
        r.idx  = idx[IDX_W-1:0];
        r.prio = prio[IN_PRIO_W-1:0];
        request_q.push_back(r);
    endtask

    // Sample at the falling edge so every update of the step has settled.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || req_ch.valid || outcome_q.size() != 0);
    endtask

    // Write task_limit while the block is idle; track it in the shadow copy.
    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        shadow_limit = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Driver: present queued requests, hold each until taken, then idle a while.
    always @(posedge i_clk) begin : request_driver
        t_request item;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            // Predict at the accepting edge so the shadow table follows the block
            if (req_ch.valid && req_ch.ready) begin
                item.op   = req_ch.opcode;
                item.idx  = req_ch.task_index;
                item.prio = req_ch.new_priority;
                outcome_q.push_back(apply_request(item));
            end
            if (req_ch.valid && !req_ch.ready) begin
                // hold the request until it is taken
            end else if (send_wait != 0) begin
                req_ch.valid <= 1'b0;
                send_wait    <= send_wait - 1;
            end else if (request_q.size() != 0) begin
                item = request_q.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.opcode       <= item.op;
                req_ch.task_index   <= item.idx;
                req_ch.new_priority <= item.prio;
                send_wait           <= no_idle ? 0 : pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result channel at random and check every result taken.
    always @(posedge i_clk) begin : result_monitor
        t_res expected;
        int   g;
        if (res_ch.valid && res_ch.ready && i_rst_n) begin
            if (outcome_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected result chosen=%0d switched=%0b status=%0d",
                             $realtime, res_ch.chosen_task, res_ch.switched,
                             res_ch.status);
            end else begin
                expected = outcome_q.pop_front();
                if (res_ch.chosen_task !== expected.chosen ||
                    res_ch.switched !== expected.switched ||
                    res_ch.status !== expected.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result mismatch exp %0d/%0b/%0d got %0d/%0b/%0d",
                                 $realtime, expected.chosen, expected.switched,
                                 expected.status, res_ch.chosen_task,
                                 res_ch.switched, res_ch.status);
                end
            end
        end
        if (recv_wait != 0) begin
            res_ch.ready <= 1'b0;
            recv_wait    <= recv_wait - 1;
        end else begin
            // Start a stall after a taken result, or now and then out of the blue
            g = 0;
            if (!no_idle && ((res_ch.valid && res_ch.ready) || $urandom_range(0, 7) == 0))
                g = pick_gap();
            if (g == 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b0;
                recv_wait    <= g - 1;
            end
        end
    end

    // Stimulus: directed corner cases, random phases, then drain all tasks.
    initial begin : stimulus
        int       p;
        int       n;
        int       r;
        int       limits[6];
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_SCHEDULE;
        req_ch.task_index   = '0;
        req_ch.new_priority = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        res_ch.ready        = 1'b0;

        // Shadow state after reset: slot 0 runs at priority 0
        for (n = 0; n < SLOT_DEPTH; n++) begin
            shadow_st[n]   = ST_UNUSED;
            shadow_prio[n] = '0;
        end
        shadow_st[0]   = ST_RUNNING;
        shadow_total   = 1;
        shadow_running = 0;
        shadow_limit   = LIMIT_W'(16);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Lone slot 0: schedule keeps it; any other index is out of range
        push_request(OP_SCHEDULE, 0, 0);
        push_request(OP_REMOVE, 15, 0);
        push_request(OP_SETPRIO, 1, 255);
        push_request(OP_SETPRIO, 0, 0);
        wait_drained();

        // Limit zero and one: every add reports a full table
        write_limit(LIMIT_W'(0));
        push_request(OP_ADD, 0, 0);
        wait_drained();
        write_limit(LIMIT_W'(1));
        push_request(OP_ADD, 0, 0);
        wait_drained();

        // Limit above the table size is capped; fill three slots and switch
        write_limit(LIMIT_W'(31));
        push_request(OP_ADD, 0, 0);
        push_request(OP_ADD, 0, 0);
        push_request(OP_SETPRIO, 2, 255);
        push_request(OP_SCHEDULE, 0, 0);
        push_request(OP_SCHEDULE, 0, 0);
        push_request(OP_SETPRIO, 1, 255);
        push_request(OP_SCHEDULE, 0, 0);
        // Drop the running task; the next schedule leaves it terminated
        push_request(OP_REMOVE, 1, 0);
        push_request(OP_SCHEDULE, 0, 0);
        push_request(OP_SETPRIO, 0, 170);
        push_request(OP_SCHEDULE, 0, 0);
        push_request(OP_REMOVE, 3, 0);
        wait_drained();

        // Random phases; the drain between phases also holds the sender
        // until every result is back
        limits = '{4, 9, 0, 16, 0, 31};
        limits[4] = $urandom_range(0, 31);
        for (p = 0; p < 6; p++) begin
            write_limit(LIMIT_W'(limits[p]));
            no_idle = (p == 2);
            for (n = 0; n < 115; n++) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    push_request(OP_SCHEDULE, $urandom_range(0, 15),
                                 $urandom_range(0, 255));
                else if (r < 55)
                    push_request(OP_ADD, $urandom_range(0, 15), $urandom_range(0, 255));
                else if (r < 58)
                    push_request(OP_REMOVE, $urandom_range(0, 15), $urandom_range(0, 255));
                else
                    // Favor low indexes and a few priorities so ties are common
                    push_request(OP_SETPRIO,
                                 ($urandom_range(0, 9) < 3) ? $urandom_range(0, 3)
                                                            : $urandom_range(0, 15),
                                 ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                                            : $urandom_range(0, 255));
            end
            wait_drained();
        end
        no_idle = 1'b0;

        // Fill the table, terminate every slot, and find nothing runnable
        write_limit(LIMIT_W'(16));
        for (n = 0; n < 15; n++)
            push_request(OP_ADD, 0, 0);
        for (n = 0; n < SLOT_DEPTH; n++)
            push_request(OP_REMOVE, n, 0);
        push_request(OP_SCHEDULE, 0, 0);
        push_request(OP_SCHEDULE, 0, 0);
        wait_drained();

        // Let any stray result surface before the verdict
        repeat (60) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb_priority_round_robin_scheduler_core OK");
        else
            $display("tb_priority_round_robin_scheduler_core NOT OK");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb_priority_round_robin_scheduler_core NOT OK");
        $finish;
    end

endmodule
